// ----- src/lmw_pkg.sv -----
// lmw_pkg: shared constants, register indexes and stage payload types
// of the local magnify warp address generator; depends on nothing
`default_nettype none

package lmw_pkg;

    localparam int MAX_DIM          = 4096;
    localparam int CENTER_FRAC_BITS = 4;
    localparam int SF_FRAC_BITS     = 16;

    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int CENTER_W = 16;
    localparam int RADIUS_W = 10;
    localparam int STREN_W  = 7;
    localparam int RQ_W     = RADIUS_W + CENTER_FRAC_BITS;
    localparam int OFF_W    = COORD_W + CENTER_FRAC_BITS + 1;
    localparam int SQ_W     = 2 * (OFF_W - 1) + 1;
    localparam int R2_W     = 2 * RQ_W;
    localparam int DEN_W    = R2_W + STREN_W;
    localparam int SF_W     = SF_FRAC_BITS + 1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_RADIUS       = 3'd2;
    localparam logic [2:0] REG_STRENGTH     = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0] radius;
        logic [STREN_W-1:0]  strength;
        logic [SIZE_W-1:0]   w_eff;
        logic [SIZE_W-1:0]   h_eff;
        logic [R2_W-1:0]     r2;
        logic [DEN_W-1:0]    den;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [OFF_W-1:0]   ox;
        logic [OFF_W-1:0]   oy;
    } pix_t;

    typedef struct packed {
        pix_t             pix;
        logic             remap;
        logic [DEN_W-1:0] num;
    } geom_t;

    typedef struct packed {
        pix_t            pix;
        logic            remap;
        logic [SF_W-1:0] sf;
    } scale_t;

endpackage

`default_nettype wire

// ----- src/lmw_regs.sv -----
// lmw_regs: apb configuration registers plus derived radius square and divisor
// depends on lmw_pkg
`default_nettype none

module lmw_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lmw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lmw_pkg::APB_DW-1:0]   pwdata,
    output logic      [lmw_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output lmw_pkg::cfg_t                     cfg
);

    logic [lmw_pkg::CENTER_W-1:0] center_x_reg;
    logic [lmw_pkg::CENTER_W-1:0] center_y_reg;
    logic [lmw_pkg::RADIUS_W-1:0] radius_reg;
    logic [lmw_pkg::STREN_W-1:0]  strength_reg;
    logic [lmw_pkg::SIZE_W-1:0]   width_reg;
    logic [lmw_pkg::SIZE_W-1:0]   height_reg;
    logic [lmw_pkg::R2_W-1:0]     r2_reg;
    logic [lmw_pkg::DEN_W-1:0]    den_reg;
    logic [lmw_pkg::RQ_W-1:0]     rq;
    logic [lmw_pkg::R2_W-1:0]     r2_next;
    logic [lmw_pkg::DEN_W-1:0]    den_next;
    logic [2:0]                   idx;
    logic                         wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= lmw_pkg::RADIUS_W'(32);
            strength_reg <= '0;
            width_reg    <= lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM);
            height_reg   <= lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM);
        end else if (wr) begin
            case (idx)
                lmw_pkg::REG_CENTER_X:     center_x_reg <= pwdata[lmw_pkg::CENTER_W-1:0];
                lmw_pkg::REG_CENTER_Y:     center_y_reg <= pwdata[lmw_pkg::CENTER_W-1:0];
                lmw_pkg::REG_RADIUS:       radius_reg   <= pwdata[lmw_pkg::RADIUS_W-1:0];
                lmw_pkg::REG_STRENGTH:     strength_reg <= pwdata[lmw_pkg::STREN_W-1:0];
                lmw_pkg::REG_IMAGE_WIDTH:  width_reg    <= pwdata[lmw_pkg::SIZE_W-1:0];
                lmw_pkg::REG_IMAGE_HEIGHT: height_reg   <= pwdata[lmw_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // derived values follow a radius write through r2_reg and then den_reg
    assign rq       = {radius_reg, {lmw_pkg::CENTER_FRAC_BITS{1'b0}}};
    assign r2_next  = lmw_pkg::R2_W'(rq) * lmw_pkg::R2_W'(rq);
    assign den_next = lmw_pkg::DEN_W'(r2_reg) * lmw_pkg::DEN_W'(100);

    always_ff @(posedge aclk) begin
        r2_reg  <= r2_next;
        den_reg <= den_next;
    end

    always_comb begin
        case (idx)
            lmw_pkg::REG_CENTER_X:     prdata = lmw_pkg::APB_DW'(center_x_reg);
            lmw_pkg::REG_CENTER_Y:     prdata = lmw_pkg::APB_DW'(center_y_reg);
            lmw_pkg::REG_RADIUS:       prdata = lmw_pkg::APB_DW'(radius_reg);
            lmw_pkg::REG_STRENGTH:     prdata = lmw_pkg::APB_DW'(strength_reg);
            lmw_pkg::REG_IMAGE_WIDTH:  prdata = lmw_pkg::APB_DW'(width_reg);
            lmw_pkg::REG_IMAGE_HEIGHT: prdata = lmw_pkg::APB_DW'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        cfg.cx       = center_x_reg;
        cfg.cy       = center_y_reg;
        cfg.radius   = radius_reg;
        cfg.strength = strength_reg;
        cfg.w_eff    = (width_reg > lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM))
                       ? lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM) : width_reg;
        cfg.h_eff    = (height_reg > lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM))
                       ? lmw_pkg::SIZE_W'(lmw_pkg::MAX_DIM) : height_reg;
        cfg.r2       = r2_reg;
        cfg.den      = den_reg;
    end

endmodule

`default_nettype wire

// ----- src/lmw_geom.sv -----
// lmw_geom: five stage front end, box test, offsets, squared distance,
// inside test and scale numerator; depends on lmw_pkg
`default_nettype none

module lmw_geom (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lmw_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lmw_pkg::COORD_W-1:0]   in_px,
    input  wire logic [lmw_pkg::COORD_W-1:0]   in_py,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lmw_pkg::geom_t                     out_data
);

    localparam int F = lmw_pkg::CENTER_FRAC_BITS;

    function automatic logic span_ok(
        input logic [lmw_pkg::COORD_W-1:0]  pix,
        input logic [lmw_pkg::CENTER_W-1:0] cq,
        input logic [lmw_pkg::RQ_W-1:0]     rq,
        input logic [lmw_pkg::SIZE_W-1:0]   size
    );
        logic signed [lmw_pkg::CENTER_W+1:0] lo;
        logic [lmw_pkg::CENTER_W:0]          hi;
        logic [lmw_pkg::COORD_W-1:0]         first;
        logic signed [lmw_pkg::SIZE_W:0]     last;
        logic signed [lmw_pkg::SIZE_W:0]     p;
        lo = $signed({2'b00, cq}) - $signed((lmw_pkg::CENTER_W+2)'(rq));
        hi = {1'b0, cq} + (lmw_pkg::CENTER_W+1)'(rq);
        first = lo[lmw_pkg::CENTER_W+1] ? '0 : lo[lmw_pkg::CENTER_W-1:F];
        if (hi >= {size, {F{1'b0}}}) begin
            last = $signed({1'b0, size}) - (lmw_pkg::SIZE_W+1)'(1);
        end else begin
            last = $signed({1'b0, hi[lmw_pkg::CENTER_W:F]});
        end
        p = $signed((lmw_pkg::SIZE_W+1)'(pix));
        return (p >= $signed((lmw_pkg::SIZE_W+1)'(first))) && (p < last);
    endfunction

    logic [lmw_pkg::RQ_W-1:0] rq;
    assign rq = {cfg.radius, {F{1'b0}}};

    // stage valids and readies
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    assign r5       = !v5_reg || out_ready;
    assign r4       = !v4_reg || r5;
    assign r3       = !v3_reg || r4;
    assign r2       = !v3_reg ? r3 : (!v2_reg || r3);
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // stage 1: box test and offsets
    lmw_pkg::pix_t pix1_reg, pix1_next;
    logic          span1_reg, span1_next;

    always_comb begin
        pix1_next.px = in_px;
        pix1_next.py = in_py;
        pix1_next.ox = {1'b0, in_px, {F{1'b0}}} - {1'b0, cfg.cx};
        pix1_next.oy = {1'b0, in_py, {F{1'b0}}} - {1'b0, cfg.cy};
        span1_next   = (cfg.radius != '0)
                       && span_ok(in_px, cfg.cx, rq, cfg.w_eff)
                       && span_ok(in_py, cfg.cy, rq, cfg.h_eff);
    end

    // stage 2: squares of the offsets
    lmw_pkg::pix_t                pix2_reg;
    logic                         span2_reg;
    logic [lmw_pkg::SQ_W-1:0]     sqx2_reg, sqx2_next;
    logic [lmw_pkg::SQ_W-1:0]     sqy2_reg, sqy2_next;
    logic signed [2*lmw_pkg::OFF_W-1:0] prx, pry;

    always_comb begin
        prx       = (2*lmw_pkg::OFF_W)'($signed(pix1_reg.ox))
                    * (2*lmw_pkg::OFF_W)'($signed(pix1_reg.ox));
        pry       = (2*lmw_pkg::OFF_W)'($signed(pix1_reg.oy))
                    * (2*lmw_pkg::OFF_W)'($signed(pix1_reg.oy));
        sqx2_next = prx[lmw_pkg::SQ_W-1:0];
        sqy2_next = pry[lmw_pkg::SQ_W-1:0];
    end

    // stage 3: distance compare and radius margin
    lmw_pkg::pix_t               pix3_reg;
    logic                        in3_reg, in3_next;
    logic [lmw_pkg::R2_W-1:0]    diff3_reg, diff3_next;
    logic [lmw_pkg::SQ_W:0]      d2;

    always_comb begin
        d2         = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        in3_next   = span2_reg && (d2 <= (lmw_pkg::SQ_W+1)'(cfg.r2));
        diff3_next = cfg.r2 - d2[lmw_pkg::R2_W-1:0];
    end

    // stage 4: strength times margin
    lmw_pkg::pix_t               pix4_reg;
    logic                        in4_reg;
    logic [lmw_pkg::DEN_W-1:0]   prod4_reg, prod4_next;

    assign prod4_next = lmw_pkg::DEN_W'(cfg.strength) * lmw_pkg::DEN_W'(diff3_reg);

    // stage 5: numerator, saturated at zero
    lmw_pkg::geom_t g5_reg, g5_next;

    always_comb begin
        g5_next.pix   = pix4_reg;
        g5_next.remap = in4_reg;
        g5_next.num   = (prod4_reg > cfg.den) ? '0 : (cfg.den - prod4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            pix1_reg  <= pix1_next;
            span1_reg <= span1_next;
        end
        if (r2 && v1_reg) begin
            pix2_reg  <= pix1_reg;
            span2_reg <= span1_reg;
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
        end
        if (r3 && v2_reg) begin
            pix3_reg  <= pix2_reg;
            in3_reg   <= in3_next;
            diff3_reg <= diff3_next;
        end
        if (r4 && v3_reg) begin
            pix4_reg  <= pix3_reg;
            in4_reg   <= in3_reg;
            prod4_reg <= prod4_next;
        end
        if (r5 && v4_reg) begin
            g5_reg <= g5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = g5_reg;

endmodule

`default_nettype wire

// ----- src/lmw_div.sv -----
// lmw_div: pipelined restoring divider, one quotient bit per stage,
// turns numerator and divisor into the q1.16 scale; depends on lmw_pkg
`default_nettype none

module lmw_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [lmw_pkg::DEN_W-1:0]    den,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire lmw_pkg::geom_t               in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output lmw_pkg::scale_t                   out_data
);

    localparam int NST = lmw_pkg::SF_W;

    typedef struct packed {
        lmw_pkg::pix_t             pix;
        logic                      remap;
        logic [lmw_pkg::DEN_W-1:0] rem;
        logic [NST-1:0]            q;
    } dstage_t;

    dstage_t        st_reg  [NST];
    dstage_t        st_next [NST];
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            assign rdy[k] = !v_reg[k] || rdy[k+1];

            if (k == 0) begin : g_first
                // num never exceeds den, so the leading bit is a plain compare
                always_comb begin
                    logic b;
                    b                 = in_data.num >= den;
                    st_next[k].pix    = in_data.pix;
                    st_next[k].remap  = in_data.remap;
                    st_next[k].rem    = b ? (in_data.num - den) : in_data.num;
                    st_next[k].q      = NST'(b);
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        v_reg[k] <= 1'b0;
                    end else if (rdy[k]) begin
                        v_reg[k] <= in_valid;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (rdy[k] && in_valid) begin
                        st_reg[k] <= st_next[k];
                    end
                end
            end else begin : g_rest
                always_comb begin
                    logic [lmw_pkg::DEN_W:0] t;
                    logic [lmw_pkg::DEN_W:0] d;
                    logic                    b;
                    t                 = {st_reg[k-1].rem, 1'b0};
                    d                 = {1'b0, den};
                    b                 = t >= d;
                    st_next[k].pix    = st_reg[k-1].pix;
                    st_next[k].remap  = st_reg[k-1].remap;
                    st_next[k].rem    = b ? (t[lmw_pkg::DEN_W-1:0] - den)
                                          : t[lmw_pkg::DEN_W-1:0];
                    st_next[k].q      = {st_reg[k-1].q[NST-2:0], b};
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        v_reg[k] <= 1'b0;
                    end else if (rdy[k]) begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end

                always_ff @(posedge aclk) begin
                    if (rdy[k] && v_reg[k-1]) begin
                        st_reg[k] <= st_next[k];
                    end
                end
            end
        end
    endgenerate

    assign in_ready        = rdy[0];
    assign out_valid       = v_reg[NST-1];
    assign out_data.pix    = st_reg[NST-1].pix;
    assign out_data.remap  = st_reg[NST-1].remap;
    assign out_data.sf     = st_reg[NST-1].q;

endmodule

`default_nettype wire

// ----- src/lmw_map.sv -----
// lmw_map: two stage back end, scales the offsets, adds the center and clamps
// to the image; its last stage is the output register; depends on lmw_pkg
`default_nettype none

module lmw_map (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lmw_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lmw_pkg::scale_t               in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_inside,
    output logic [lmw_pkg::COORD_W-1:0]        out_x,
    output logic [lmw_pkg::COORD_W-1:0]        out_y
);

    localparam int PW   = lmw_pkg::OFF_W + lmw_pkg::SF_W + 1;
    localparam int POSW = PW + 1;
    localparam int SH   = lmw_pkg::CENTER_FRAC_BITS + lmw_pkg::SF_FRAC_BITS;
    localparam int IPW  = POSW - 1 - SH;

    function automatic logic [lmw_pkg::COORD_W-1:0] place(
        input logic [PW-1:0]                 prod,
        input logic [lmw_pkg::CENTER_W-1:0]  cq,
        input logic [lmw_pkg::SIZE_W-1:0]    size
    );
        logic signed [POSW-1:0]     pos;
        logic [IPW-1:0]             ip;
        logic [lmw_pkg::SIZE_W-1:0] lim;
        pos = $signed({prod[PW-1], prod})
              + $signed(POSW'({cq, {lmw_pkg::SF_FRAC_BITS{1'b0}}}));
        ip  = pos[POSW-1] ? '0 : pos[POSW-2:SH];
        lim = size - lmw_pkg::SIZE_W'(1);
        if (ip >= IPW'(size)) begin
            ip = IPW'(lim);
        end
        return ip[lmw_pkg::COORD_W-1:0];
    endfunction

    logic v1_reg, v2_reg;
    logic r1, r2;

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // stage 1: offset times scale
    lmw_pkg::pix_t   pix1_reg;
    logic            in1_reg;
    logic [PW-1:0]   prx1_reg, prx1_next;
    logic [PW-1:0]   pry1_reg, pry1_next;

    always_comb begin
        prx1_next = PW'($signed(in_data.pix.ox)) * PW'($signed({1'b0, in_data.sf}));
        pry1_next = PW'($signed(in_data.pix.oy)) * PW'($signed({1'b0, in_data.sf}));
    end

    // stage 2: add center, floor, clamp, select
    logic                          in2_reg;
    logic [lmw_pkg::COORD_W-1:0]   x2_reg, x2_next;
    logic [lmw_pkg::COORD_W-1:0]   y2_reg, y2_next;

    always_comb begin
        if (in1_reg) begin
            x2_next = place(prx1_reg, cfg.cx, cfg.w_eff);
            y2_next = place(pry1_reg, cfg.cy, cfg.h_eff);
        end else begin
            x2_next = pix1_reg.px;
            y2_next = pix1_reg.py;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            pix1_reg <= in_data.pix;
            in1_reg  <= in_data.remap;
            prx1_reg <= prx1_next;
            pry1_reg <= pry1_next;
        end
        if (r2 && v1_reg) begin
            in2_reg <= in1_reg;
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
        end
    end

    assign out_valid  = v2_reg;
    assign out_inside = in2_reg;
    assign out_x      = x2_reg;
    assign out_y      = y2_reg;

endmodule

`default_nettype wire

// ----- src/local_magnify_warp_address.sv -----
// local_magnify_warp_address: top level of the bulge warp address generator
// depends on lmw_pkg, lmw_regs, lmw_geom, lmw_div, lmw_map
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   s_       | s_valid / s_ready      | s_pixel_x, s_pixel_y
//   m_       | m_valid / m_ready      | m_inside_res, m_source_x, m_source_y
//   apb      | psel, penable, pready  | paddr, pwdata, prdata
//
// one request per clock while the output is not stalled: 5 geometry stages, 17 divider
// stages (one quotient bit each), 2 mapping stages ending in the output register
// synchronous active-low reset empties every stage and restores register defaults
// each stage holds while the next one is full and stalled; empty stages fill in,
// so the input keeps taking requests until the whole pipe is full
`default_nettype none

module local_magnify_warp_address (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmw_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lmw_pkg::APB_DW-1:0]    pwdata,
    output logic      [lmw_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lmw_pkg::COORD_W-1:0]   s_pixel_x,
    input  wire logic [lmw_pkg::COORD_W-1:0]   s_pixel_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_inside_res,
    output logic      [lmw_pkg::COORD_W-1:0]   m_source_x,
    output logic      [lmw_pkg::COORD_W-1:0]   m_source_y
);

    lmw_pkg::cfg_t   cfg;
    lmw_pkg::geom_t  geom_data;
    lmw_pkg::scale_t scale_data;
    logic            geom_valid, geom_ready;
    logic            scale_valid, scale_ready;

    lmw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmw_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_px     (s_pixel_x),
        .in_py     (s_pixel_y),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_data  (geom_data)
    );

    lmw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .den       (cfg.den),
        .in_valid  (geom_valid),
        .in_ready  (geom_ready),
        .in_data   (geom_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    lmw_map u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (scale_valid),
        .in_ready   (scale_ready),
        .in_data    (scale_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_inside (m_inside_res),
        .out_x      (m_source_x),
        .out_y      (m_source_y)
    );

endmodule

`default_nettype wire
